// ----- rtl/qvr_pkg.sv -----
// Package for the quaternion vector rotation block: field widths, fixed-point
// format and the packed item types of the request and response channels.
// No dependencies.
package qvr_pkg;

   localparam int unsigned VEC_WIDTH = 16;
   localparam int unsigned FRAC_BITS = 14;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0] vec_x;
      logic signed [VEC_WIDTH-1:0] vec_y;
      logic signed [VEC_WIDTH-1:0] vec_z;
      logic signed [VEC_WIDTH-1:0] quat_w;
      logic signed [VEC_WIDTH-1:0] quat_i;
      logic signed [VEC_WIDTH-1:0] quat_j;
      logic signed [VEC_WIDTH-1:0] quat_k;
   } req_type;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0] rot_x;
      logic signed [VEC_WIDTH-1:0] rot_y;
      logic signed [VEC_WIDTH-1:0] rot_z;
      logic                        saturated;
   } rsp_type;

endpackage

// ----- rtl/qvr_round_sat.sv -----
// Round-to-nearest (ties up), arithmetic shift by FRAC_BITS and signed
// saturation to OUT_W bits. Purely combinational. No package dependency.
module qvr_round_sat #(
   parameter int IN_W      = 34,
   parameter int OUT_W     = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic signed [IN_W-1:0]  sum,
   output logic signed [OUT_W-1:0] result,
   output logic                    clip
);

   localparam int RW = IN_W + 1 - FRAC_BITS;
   localparam logic signed [IN_W:0] HALF = (IN_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic signed [OUT_W-1:0] MAX_VAL = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] MIN_VAL = {1'b1, {(OUT_W-1){1'b0}}};

   logic signed [IN_W:0]   biased;
   logic signed [RW-1:0]   rnd;
   logic [RW-OUT_W:0]      top_bits;
   logic                   fits;

   always_comb begin
      biased   = (IN_W + 1)'(sum) + HALF;
      rnd      = biased[IN_W:FRAC_BITS];
      top_bits = rnd[RW-1:OUT_W-1];
      fits     = (&top_bits) | ~(|top_bits);
      if (fits) begin
         result = rnd[OUT_W-1:0];
      end else if (rnd[RW-1]) begin
         result = MIN_VAL;
      end else begin
         result = MAX_VAL;
      end
      clip = ~fits;
   end

endmodule

// ----- rtl/quaternion_vector_rotate.sv -----
// Quaternion vector rotation, top level: four-stage pipeline computing
// q * (0,v) * conj(q) in fixed point. Uses qvr_pkg and qvr_round_sat.
//
// Usage:
//   Request channel req_valid/req_ready/req_data carries one item: a vector
//   (signed integers) and a quaternion (signed, FRAC_BITS fraction bits).
//   Response channel rsp_valid/rsp_ready/rsp_data returns the rotated vector,
//   rounded to nearest and saturated, with a flag set when any component was
//   clipped (possible for a non-unit quaternion).
//   Stages: A q*v products, B first sum and round, C t*conj(q) products,
//   D second sum, round and saturate; an item passes through them in order.
//   Throughput: one item per cycle while rsp_ready is high.
//   rsp_valid rises once the item is registered in stage D.
//   Each stage holds while the stage after it is full and stalled; bubbles
//   are filled, so req_ready drops only once all four stages are full and
//   rsp_ready is low. Nothing is dropped or repeated under a stall.
//   Reset (synchronous, active high) empties the pipeline; items in flight
//   are discarded. No configuration.
module quaternion_vector_rotate #(
   parameter int FRAC_BITS = qvr_pkg::FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qvr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qvr_pkg::rsp_type rsp_data
);

   localparam int V   = qvr_pkg::VEC_WIDTH;
   localparam int PW1 = 2 * V;
   localparam int SW1 = PW1 + 2;
   localparam int TW  = SW1 + 1 - FRAC_BITS;
   localparam int PW2 = TW + V;
   localparam int SW2 = PW2 + 2;

   typedef struct packed {
      logic signed [V-1:0] w;
      logic signed [V-1:0] i;
      logic signed [V-1:0] j;
      logic signed [V-1:0] k;
   } quat_type;

   logic [3:0] valid_ff, valid_in;
   logic rdy_a, rdy_b, rdy_c, rdy_d;

   logic signed [PW1-1:0] pa_ff [12];
   logic signed [PW1-1:0] pa_in [12];
   quat_type              qa_ff, qa_in;

   logic signed [SW1-1:0] s1 [4];
   logic signed [TW-1:0]  t_rnd [4];
   logic [3:0]            t_clip;
   logic signed [TW-1:0]  tb_ff [4];
   quat_type              qb_ff;

   logic signed [PW2-1:0] pc_ff [12];
   logic signed [PW2-1:0] pc_in [12];

   logic signed [SW2-1:0] s2 [3];
   logic signed [V-1:0]   r_sat [3];
   logic [2:0]            r_clip;
   qvr_pkg::rsp_type      rsp_ff, rsp_in;

   assign rdy_d     = ~valid_ff[3] | rsp_ready;
   assign rdy_c     = ~valid_ff[2] | rdy_d;
   assign rdy_b     = ~valid_ff[1] | rdy_c;
   assign rdy_a     = ~valid_ff[0] | rdy_b;
   assign req_ready = rdy_a;
   assign rsp_valid = valid_ff[3];
   assign rsp_data  = rsp_ff;

   always_comb begin
      valid_in[0] = rdy_a ? req_valid   : valid_ff[0];
      valid_in[1] = rdy_b ? valid_ff[0] : valid_ff[1];
      valid_in[2] = rdy_c ? valid_ff[1] : valid_ff[2];
      valid_in[3] = rdy_d ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage A: q * (0,v) products
   always_comb begin
      qa_in.w   = req_data.quat_w;
      qa_in.i   = req_data.quat_i;
      qa_in.j   = req_data.quat_j;
      qa_in.k   = req_data.quat_k;
      pa_in[0]  = req_data.quat_i * req_data.vec_x;
      pa_in[1]  = req_data.quat_j * req_data.vec_y;
      pa_in[2]  = req_data.quat_k * req_data.vec_z;
      pa_in[3]  = req_data.quat_w * req_data.vec_x;
      pa_in[4]  = req_data.quat_j * req_data.vec_z;
      pa_in[5]  = req_data.quat_k * req_data.vec_y;
      pa_in[6]  = req_data.quat_w * req_data.vec_y;
      pa_in[7]  = req_data.quat_i * req_data.vec_z;
      pa_in[8]  = req_data.quat_k * req_data.vec_x;
      pa_in[9]  = req_data.quat_w * req_data.vec_z;
      pa_in[10] = req_data.quat_i * req_data.vec_y;
      pa_in[11] = req_data.quat_j * req_data.vec_x;
   end

   always_ff @(posedge clock) begin
      if (req_valid && rdy_a) begin
         pa_ff <= pa_in;
         qa_ff <= qa_in;
      end
   end

   // stage B: sums and rounding of t
   always_comb begin
      s1[0] = -SW1'(pa_ff[0]) - SW1'(pa_ff[1]) - SW1'(pa_ff[2]);
      s1[1] =  SW1'(pa_ff[3]) + SW1'(pa_ff[4]) - SW1'(pa_ff[5]);
      s1[2] =  SW1'(pa_ff[6]) - SW1'(pa_ff[7]) + SW1'(pa_ff[8]);
      s1[3] =  SW1'(pa_ff[9]) + SW1'(pa_ff[10]) - SW1'(pa_ff[11]);
   end

   for (genvar g = 0; g < 4; g++) begin : g_round_t
      qvr_round_sat #(
         .IN_W      (SW1),
         .OUT_W     (TW),
         .FRAC_BITS (FRAC_BITS)
      ) u_round_t (
         .sum    (s1[g]),
         .result (t_rnd[g]),
         .clip   (t_clip[g])
      );
   end

   always_ff @(posedge clock) begin
      if (valid_ff[0] && rdy_b) begin
         tb_ff <= t_rnd;
         qb_ff <= qa_ff;
      end
   end

   // stage C: t * conj(q) products
   always_comb begin
      pc_in[0]  = tb_ff[0] * qb_ff.i;
      pc_in[1]  = tb_ff[1] * qb_ff.w;
      pc_in[2]  = tb_ff[2] * qb_ff.k;
      pc_in[3]  = tb_ff[3] * qb_ff.j;
      pc_in[4]  = tb_ff[0] * qb_ff.j;
      pc_in[5]  = tb_ff[1] * qb_ff.k;
      pc_in[6]  = tb_ff[2] * qb_ff.w;
      pc_in[7]  = tb_ff[3] * qb_ff.i;
      pc_in[8]  = tb_ff[0] * qb_ff.k;
      pc_in[9]  = tb_ff[1] * qb_ff.j;
      pc_in[10] = tb_ff[2] * qb_ff.i;
      pc_in[11] = tb_ff[3] * qb_ff.w;
   end

   always_ff @(posedge clock) begin
      if (valid_ff[1] && rdy_c) begin
         pc_ff <= pc_in;
      end
   end

   // stage D: sums, rounding, saturation
   always_comb begin
      s2[0] = -SW2'(pc_ff[0]) + SW2'(pc_ff[1]) - SW2'(pc_ff[2])  + SW2'(pc_ff[3]);
      s2[1] = -SW2'(pc_ff[4]) + SW2'(pc_ff[5]) + SW2'(pc_ff[6])  - SW2'(pc_ff[7]);
      s2[2] = -SW2'(pc_ff[8]) - SW2'(pc_ff[9]) + SW2'(pc_ff[10]) + SW2'(pc_ff[11]);
   end

   for (genvar g = 0; g < 3; g++) begin : g_round_r
      qvr_round_sat #(
         .IN_W      (SW2),
         .OUT_W     (V),
         .FRAC_BITS (FRAC_BITS)
      ) u_round_r (
         .sum    (s2[g]),
         .result (r_sat[g]),
         .clip   (r_clip[g])
      );
   end

   always_comb begin
      rsp_in.rot_x     = r_sat[0];
      rsp_in.rot_y     = r_sat[1];
      rsp_in.rot_z     = r_sat[2];
      rsp_in.saturated = |r_clip;
   end

   always_ff @(posedge clock) begin
      if (valid_ff[2] && rdy_d) begin
         rsp_ff <= rsp_in;
      end
   end

   a_accept_fills_a: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted item not captured in first stage");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_ready) |-> !req_ready)
      else $error("request accepted while pipeline full and stalled");

   a_stage_a_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && !rdy_b) |=> (valid_ff[0] && $stable(qa_ff)))
      else $error("first stage lost its item during a stall");

   a_stage_c_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !rdy_d) |=> valid_ff[2])
      else $error("third stage lost its item during a stall");

   a_t_no_clip: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (t_clip == '0))
      else $error("intermediate t exceeded its width");

endmodule
